// File: hw/rtl/fxalu_pkg.sv
// Shared types, opcodes and constants of the fixed-point ALU.
`timescale 1ns / 1ps
package fxalu_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 8;
   localparam int NUM_BITS = WORD_BITS + FRAC_BITS;
   localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
   localparam int PIPE_DEPTH = DIV_STEPS + 2;
   localparam int QDEPTH = 4;
   localparam int QPTR = $clog2(QDEPTH);

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_INC = 4'd4, OP_DEC = 4'd5, OP_MIN = 4'd6, OP_MAX = 4'd7,
      OP_CMP = 4'd8, OP_FROM_INT = 4'd9, OP_TO_INT = 4'd10
   } opcode_type;

   typedef struct packed {
      logic [3:0]                   opcode;
      logic signed [WORD_BITS-1:0]  operand_a;
      logic signed [WORD_BITS-1:0]  operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0]  result;
      logic                         a_greater;
      logic                         a_equal;
      logic                         a_less;
      logic                         divide_by_zero;
   } rsp_type;

   // Classified item handed from the front part to the back part.
   typedef struct packed {
      logic [3:0]           opcode;
      logic [WORD_BITS-1:0] simple_result;
      logic                 is_mul;
      logic                 is_div;
      logic                 negate;
      logic [WORD_BITS-1:0] mag_a;
      logic [WORD_BITS-1:0] mag_b;
      logic                 a_greater;
      logic                 a_equal;
      logic                 a_less;
      logic                 divide_by_zero;
   } work_type;
endpackage

// File: hw/rtl/fxalu_front.sv
// Front part: decodes one beat, does the simple operations and compares.
`timescale 1ns / 1ps
module fxalu_front import fxalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_data,
   output logic     in_ready,
   output logic     out_valid,
   output work_type out_data,
   input  logic     out_ready
);
   logic     valid_ff, valid_in;
   work_type data_ff, data_in;
   logic [WORD_BITS-1:0] a, b, ma, mb;
   logic neg_a, neg_b, lt, gt, eq;

   assign a = in_data.operand_a;
   assign b = in_data.operand_b;
   assign neg_a = a[WORD_BITS-1];
   assign neg_b = b[WORD_BITS-1];
   assign ma = neg_a ? (~a + 1'b1) : a;
   assign mb = neg_b ? (~b + 1'b1) : b;
   assign lt = $signed(a) < $signed(b);
   assign gt = $signed(a) > $signed(b);
   assign eq = a == b;
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = '0;
      data_in.opcode = in_data.opcode;
      data_in.mag_a = ma;
      data_in.mag_b = mb;
      data_in.negate = neg_a ^ neg_b;
      data_in.a_greater = gt;
      data_in.a_equal = eq;
      data_in.a_less = lt;
      case (in_data.opcode)
         OP_ADD: data_in.simple_result = a + b;
         OP_SUB: data_in.simple_result = a - b;
         OP_MUL: data_in.is_mul = 1'b1;
         OP_DIV: begin
            data_in.is_div = (b != '0);
            data_in.divide_by_zero = (b == '0);
         end
         OP_INC: data_in.simple_result = a + 1'b1;
         OP_DEC: data_in.simple_result = a - 1'b1;
         OP_MIN: data_in.simple_result = lt ? a : b;
         OP_MAX: data_in.simple_result = lt ? b : a;
         OP_FROM_INT: data_in.simple_result = a << FRAC_BITS;
         OP_TO_INT: begin
            data_in.simple_result = neg_a ? (~(ma >> FRAC_BITS) + 1'b1) : (ma >> FRAC_BITS);
         end
         default: data_in.simple_result = '0;
      endcase
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

// File: hw/rtl/fxalu_queue.sv
// Short first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps
module fxalu_queue import fxalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output work_type pop_data,
   output logic     empty
);
   work_type mem_ff [QDEPTH];
   logic [QPTR-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR:0]   cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = cnt_ff == (QPTR+1)'(QDEPTH);
   assign empty = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];
   assign wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + (QPTR+1)'(do_push) - (QPTR+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR+1)'(QDEPTH)) else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == (QPTR+1)'(QDEPTH)) |-> wr_ff == rd_ff)
      else $error("queue pointers disagree with count");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not advance");
endmodule

// File: hw/rtl/fxalu_back.sv
// Back part: pipelined multiply and divide, result selection and output register.
`timescale 1ns / 1ps
module fxalu_back import fxalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_data,
   output logic     in_ready,
   output logic     rsp_empty,
   output rsp_type  rsp_data,
   input  logic     rsp_pop
);
   // Stage arrays: one entry per pipeline stage, each fixed in place.
   logic                   v_ff   [PIPE_DEPTH+1];
   work_type               w_ff   [PIPE_DEPTH+1];
   logic [WORD_BITS:0]     rem_ff [PIPE_DEPTH+1];
   logic [NUM_BITS-1:0]    num_ff [PIPE_DEPTH+1];
   logic [2*WORD_BITS-1:0] prod_ff;
   // Product delay line: entry i travels alongside stage i+1.
   logic [2*WORD_BITS-1:0] pline_ff [PIPE_DEPTH];
   logic                   take, emit, advance;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, final_rsp;

   // The whole pipeline holds only when its last stage has a result and the
   // output register is still occupied and not being popped.
   assign advance = !v_ff[PIPE_DEPTH] || !out_valid_ff || rsp_pop;
   assign in_ready = advance;
   assign take = in_valid && advance;
   assign emit = advance && v_ff[PIPE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= PIPE_DEPTH; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= take;
         for (int i = 1; i <= PIPE_DEPTH; i++) v_ff[i] <= v_ff[i-1];
      end
      if (advance) begin
         w_ff[0] <= in_data;
         rem_ff[0] <= '0;
         num_ff[0] <= {in_data.mag_a, FRAC_BITS'(0)};
         prod_ff <= in_data.mag_a * in_data.mag_b;
         // One restoring division step per stage.
         for (int i = 1; i <= DIV_STEPS; i++) begin
            logic [WORD_BITS:0] trial;
            trial = {rem_ff[i-1][WORD_BITS-1:0], num_ff[i-1][NUM_BITS-1]};
            w_ff[i] <= w_ff[i-1];
            if (trial >= {1'b0, w_ff[i-1].mag_b}) begin
               rem_ff[i] <= trial - {1'b0, w_ff[i-1].mag_b};
               num_ff[i] <= {num_ff[i-1][NUM_BITS-2:0], 1'b1};
            end else begin
               rem_ff[i] <= trial;
               num_ff[i] <= {num_ff[i-1][NUM_BITS-2:0], 1'b0};
            end
         end
         for (int i = DIV_STEPS + 1; i <= PIPE_DEPTH; i++) begin
            w_ff[i] <= w_ff[i-1];
            rem_ff[i] <= rem_ff[i-1];
            num_ff[i] <= num_ff[i-1];
         end
         pline_ff[0] <= prod_ff;
         for (int i = 1; i < PIPE_DEPTH; i++) pline_ff[i] <= pline_ff[i-1];
      end
   end

   // Final rounding at the last stage.
   logic [2*WORD_BITS-1:0] prnd;
   logic [WORD_BITS-1:0]   pmag, qmag, qrnd, mag, res;
   logic [WORD_BITS:0]     rem_last, den_last;
   work_type               wl;
   assign wl = w_ff[PIPE_DEPTH];
   assign prnd = pline_ff[PIPE_DEPTH-1] + (2*WORD_BITS)'(1 << (FRAC_BITS-1));
   assign pmag = prnd[FRAC_BITS +: WORD_BITS];
   assign rem_last = rem_ff[PIPE_DEPTH];
   assign den_last = {1'b0, wl.mag_b};
   assign qmag = num_ff[PIPE_DEPTH][WORD_BITS-1:0];
   assign qrnd = qmag + WORD_BITS'(rem_last >= den_last - rem_last);
   assign mag = wl.is_mul ? pmag : qrnd;
   assign res = wl.negate ? (~mag + 1'b1) : mag;

   always_comb begin
      final_rsp.result = (wl.is_mul || wl.is_div) ? res : wl.simple_result;
      final_rsp.a_greater = wl.a_greater;
      final_rsp.a_equal = wl.a_equal;
      final_rsp.a_less = wl.a_less;
      final_rsp.divide_by_zero = wl.divide_by_zero;
   end

   assign out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (emit) begin
         out_ff <= final_rsp;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      !advance |=> v_ff[PIPE_DEPTH] && out_valid_ff) else $error("stalled result lost");
   a_no_take_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |-> !take) else $error("beat taken while stalled");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff && $stable(out_ff))
      else $error("waiting result changed");
endmodule

// File: hw/rtl/fixed_point_alu.sv
// Top level of the signed Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
// The ALU takes one beat per cycle on the request queue side while req_full is
// low and returns one result beat per request, in order, on the response queue
// side. A front part decodes the opcode and computes add, subtract, increment,
// decrement, min, max, integer conversions and the comparison flags; a
// four-entry queue hands each beat to the back part, a pipeline of 43 register
// stages (one that captures the operands and forms the product, 40 restoring
// divider steps and two spare stages) that all beats pass so order is kept;
// rounding is done on the way into a single output register. Throughput is
// one beat per cycle when nothing stalls, since every divider step is its own
// stage. When a result waits unpopped and the last stage holds another, the
// back pipeline holds, then the queue and the front fill and req_full rises.
// Multiply and divide round to nearest with ties away from zero; a divide by
// zero returns 0 and raises divide_by_zero.
module fixed_point_alu import fxalu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty
);
   logic     f_valid, q_full, q_empty, b_ready;
   work_type f_data, q_data;
   logic     in_ready;

   assign req_full = !in_ready;

   fxalu_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_push), .in_data(req_data), .in_ready(in_ready),
      .out_valid(f_valid), .out_data(f_data), .out_ready(!q_full)
   );

   fxalu_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_data(f_data), .full(q_full),
      .pop(b_ready), .pop_data(q_data), .empty(q_empty)
   );

   fxalu_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(!q_empty), .in_data(q_data), .in_ready(b_ready),
      .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
   );
endmodule

// File: tb/fixed_point_alu_tb.sv
// Self-checking testbench of the fixed-point ALU: random and directed beats against a predictor.
`timescale 1ns / 1ps
module fixed_point_alu_tb;
   import fxalu_pkg::*;

   localparam int WB = WORD_BITS;
   localparam int FB = FRAC_BITS;
   localparam longint LIMIT = 400000;

   // Result prediction for one request, computed on magnitudes the same way
   // the hardware rounds: to nearest, ties away from zero.
   function automatic rsp_type alu_predict(req_type rq);
      rsp_type r;
      logic [WB-1:0] a, b, ma, mb;
      logic [2*WB-1:0] prod;
      logic [WB+FB-1:0] num, quo, rem;
      logic [WB-1:0] mag;
      logic neg;
      a = rq.operand_a;
      b = rq.operand_b;
      ma = a[WB-1] ? -a : a;
      mb = b[WB-1] ? -b : b;
      neg = a[WB-1] ^ b[WB-1];
      r = '0;
      r.a_greater = $signed(a) > $signed(b);
      r.a_equal = a == b;
      r.a_less = $signed(a) < $signed(b);
      case (rq.opcode)
         OP_ADD: r.result = a + b;
         OP_SUB: r.result = a - b;
         OP_MUL: begin
            prod = ma * mb + (1 << (FB - 1));
            mag = prod[FB +: WB];
            r.result = neg ? -mag : mag;
         end
         OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               num = {ma, {FB{1'b0}}};
               quo = num / mb;
               rem = num % mb;
               if (rem >= mb - rem) quo = quo + 1;
               mag = quo[WB-1:0];
               r.result = neg ? -mag : mag;
            end
         end
         OP_INC: r.result = a + 1;
         OP_DEC: r.result = a - 1;
         OP_MIN: r.result = r.a_less ? a : b;
         OP_MAX: r.result = r.a_less ? b : a;
         OP_FROM_INT: r.result = a << FB;
         OP_TO_INT: begin
            mag = ma >> FB;
            r.result = a[WB-1] ? -mag : mag;
         end
         default: r.result = '0;
      endcase
      return r;
   endfunction

   // Holds the responses still owed by the ALU, oldest first.
   class alu_scoreboard;
      rsp_type pending[$];
      int errors = 0;

      function void note_request(req_type rq);
         pending.push_back(alu_predict(rq));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.result !== want.result)
            $display("%0t: result expected %h actual %h", $time, want.result, got.result);
         if (got.a_greater !== want.a_greater)
            $display("%0t: a_greater expected %b actual %b", $time, want.a_greater,
                     got.a_greater);
         if (got.a_equal !== want.a_equal)
            $display("%0t: a_equal expected %b actual %b", $time, want.a_equal, got.a_equal);
         if (got.a_less !== want.a_less)
            $display("%0t: a_less expected %b actual %b", $time, want.a_less, got.a_less);
         if (got.divide_by_zero !== want.divide_by_zero)
            $display("%0t: divide_by_zero expected %b actual %b", $time,
                     want.divide_by_zero, got.divide_by_zero);
         if (got !== want) errors++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   req_type req_data = '0;
   logic req_full;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic rsp_empty;

   alu_scoreboard board = new();
   longint cycles = 0;
   bit sending_done = 0;
   bit calm = 0;      // Set for the last part of the run: no idling on either side.
   bit hold_off = 0;  // Long receiver stall that fills the ALU and stalls its input.

   fixed_point_alu dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data), .rsp_empty(rsp_empty)
   );

   always #10 clock = ~clock;

   // Cycle counter that ends a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Operand with a bias toward the edges of the signed range and small values.
   function automatic logic [WB-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
         3: return $urandom_range(0, 2047) - 1024;
         4: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 8);
         default: return $urandom;
      endcase
   endfunction

   // Offers one beat and holds it until the ALU takes it. The data changes
   // only at an edge where the previous beat was accepted or push was low,
   // so push stays high across back-to-back beats without a glitch.
   task automatic send_beat(req_type rq);
      req_push <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(rq);
   endtask

   task automatic sender_idle();
      int gap;
      if (calm || $urandom_range(0, 3) != 0) return;
      gap = $urandom_range(1, 16);
      req_push <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   function automatic req_type make_beat(logic [3:0] op, logic [WB-1:0] a,
                                         logic [WB-1:0] b);
      req_type rq;
      rq.opcode = op;
      rq.operand_a = a;
      rq.operand_b = b;
      return rq;
   endfunction

   // Sender process: directed beats, then random ones.
   initial begin
      logic [3:0] op;
      logic [WB-1:0] a, b;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, every opcode, ties in rounding, divide by zero,
      // unused opcodes, negative truncation in the integer conversion.
      send_beat(make_beat(OP_ADD, 32'h7fff_ffff, 32'h0000_0001));
      send_beat(make_beat(OP_SUB, 32'h8000_0000, 32'h0000_0001));
      send_beat(make_beat(OP_MUL, 32'h0000_0180, 32'h0000_0101));
      send_beat(make_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000));
      send_beat(make_beat(OP_MUL, 32'hffff_ff80, 32'h0000_0001));
      send_beat(make_beat(OP_DIV, 32'h0000_0100, 32'h0000_0000));
      send_beat(make_beat(OP_DIV, 32'h0000_0001, 32'h0000_0200));
      send_beat(make_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff));
      send_beat(make_beat(OP_DIV, 32'h7fff_ffff, 32'h0000_0001));
      send_beat(make_beat(OP_DIV, 32'hffff_ff00, 32'h0000_0300));
      send_beat(make_beat(OP_INC, 32'h7fff_ffff, 32'h0));
      send_beat(make_beat(OP_DEC, 32'h8000_0000, 32'h0));
      send_beat(make_beat(OP_MIN, 32'h8000_0000, 32'h7fff_ffff));
      send_beat(make_beat(OP_MAX, 32'h8000_0000, 32'h7fff_ffff));
      send_beat(make_beat(OP_CMP, 32'h1234_5678, 32'h1234_5678));
      send_beat(make_beat(OP_CMP, 32'hffff_ffff, 32'h0000_0000));
      send_beat(make_beat(OP_FROM_INT, 32'hffff_ffff, 32'h0));
      send_beat(make_beat(OP_FROM_INT, 32'h0100_0000, 32'h0));
      send_beat(make_beat(OP_TO_INT, 32'hffff_ff01, 32'h0));
      send_beat(make_beat(OP_TO_INT, 32'h8000_0000, 32'h0));
      send_beat(make_beat(4'd11, 32'h5, 32'h3));
      send_beat(make_beat(4'd15, 32'hffff_ffff, 32'hffff_ffff));
      for (int i = 0; i < 950; i++) begin
         if (i == 800) calm = 1;
         op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(0, 10));
         a = pick_operand();
         b = ($urandom_range(0, 15) == 0) ? '0 : pick_operand();
         sender_idle();
         send_beat(make_beat(op, a, b));
      end
      req_push <= 1'b0;
      sending_done = 1;
   end

   // Receiver process: random pop bursts, one long stall early on.
   initial begin
      int gap;
      @(negedge reset);
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
      join_none
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) board.check_response(rsp_data);
         if (hold_off) begin
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            rsp_pop <= 1'b0;
            repeat (gap) begin
               @(posedge clock);
            end
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // End of run: wait until everything owed has arrived, then wait on to catch
   // stray responses.
   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// File: sim.f
hw/rtl/fxalu_pkg.sv
hw/rtl/fxalu_front.sv
hw/rtl/fxalu_queue.sv
hw/rtl/fxalu_back.sv
hw/rtl/fixed_point_alu.sv
tb/fixed_point_alu_tb.sv
